### rtl/bus_transaction_queue_unit_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef BUS_TRANSACTION_QUEUE_UNIT_DEFINES_SVH
`define BUS_TRANSACTION_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btq_pkg.sv
// Shared types, constants and helpers for the bus transaction queue.
package btq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * DEPTH);
  localparam int ADDR_W = 13;
  localparam int REQ_W  = 3;

  localparam logic [15:0] ADDR_CUT  = 16'h1fff;
  localparam logic [15:0] FULL_MASK = 16'hffff;

  localparam logic [REQ_W-1:0] REQ_INJECT_AUTO = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INJECT_AT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STUFF       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_YIELD       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FETCH       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET_AUTO    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_PEEK        = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [15:0]       mask;
    logic [7:0]        value;
    logic              drive;
    logic [63:0]       stamp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
    entry_t           data;
  } wr_t;

  // ring position idx + off, off at most DEPTH
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/btq_if.sv
// Request and response channel interfaces of the bus transaction queue.
interface btq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] address;
  logic [7:0]  value;
  logic [15:0] mask;
  logic [63:0] timestamp;

  modport source (output valid, req_type, address, value, mask, timestamp, input ready);
  modport sink   (input valid, req_type, address, value, mask, timestamp, output ready);
endinterface

interface btq_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        bus_drive;
  logic [7:0]  bus_value;
  logic [12:0] head_address;
  logic        overflow;
  logic        pending;
  logic [5:0]  entry_count;
  logic [15:0] next_inject_address;

  modport source (output valid, hit, bus_drive, bus_value, head_address, overflow,
                  pending, entry_count, next_inject_address, input ready);
  modport sink   (input valid, hit, bus_drive, bus_value, head_address, overflow,
                  pending, entry_count, next_inject_address, output ready);
endinterface

### rtl/btq_store.sv
// Entry memory with registered head entry and prefetched successor.
module btq_store (
  input  logic                     clk,
  input  btq_pkg::wr_t             wr,
  input  logic                     pop,
  input  logic [btq_pkg::IDX_W-1:0] head_idx,
  input  logic [btq_pkg::IDX_W-1:0] head_idx_next,
  output btq_pkg::entry_t          head
);

  btq_pkg::entry_t                  mem [btq_pkg::DEPTH];
  btq_pkg::entry_t                  succ;
  logic [btq_pkg::IDX_W-1:0]        rd_addr;

  assign rd_addr = btq_pkg::idx_add(head_idx_next, btq_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.pos] <= wr.data;
    end
    if (wr.en && wr.pos == rd_addr) begin
      succ <= wr.data;
    end else begin
      succ <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head <= succ;
    end else if (wr.en && wr.pos == head_idx) begin
      head <= wr.data;
    end
  end

endmodule

### rtl/bus_transaction_queue_unit.sv
// Top level of the bus transaction queue: request decode, pointers, result register.
//
//   channel | dir | transaction
//   req     | in  | req_type, address, value, mask, timestamp
//   rsp     | out | hit, bus_drive, bus_value, head_address, overflow, pending,
//           |     | entry_count, next_inject_address
//
// One transaction per cycle unless stalled; its result is registered for the next cycle.
// Head and its successor are held in registers, so a pop needs no memory read latency.
// rst clears pointers, count, auto address and the result valid; entries are not cleared.
// req.ready drops only while a result waits and rsp.ready is low.
`include "bus_transaction_queue_unit_defines.svh"

module bus_transaction_queue_unit (
  input logic      clk,
  input logic      rst,
  btq_req_if.sink  req,
  btq_rsp_if.source rsp
);

  logic [btq_pkg::IDX_W-1:0] head_idx, head_idx_next;
  logic [btq_pkg::IDX_W-1:0] tail_pos;
  logic [btq_pkg::CNT_W-1:0] count, count_next;
  logic [15:0]               auto_addr, auto_addr_next;
  logic [btq_pkg::ADDR_W-1:0] tail_addr, tail_addr_next;

  logic                      acc;
  logic                      is_push, is_drive, is_fetch, is_peek, is_set, is_inject;
  logic [15:0]               push_addr;
  logic                      replace, full, drop;
  logic                      fetch_hit, pop, show;
  btq_pkg::entry_t           new_entry, head;
  btq_pkg::wr_t              wr;

  assign acc       = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  always_comb begin
    is_push   = 1'b0;
    is_drive  = 1'b1;
    is_fetch  = 1'b0;
    is_peek   = 1'b0;
    is_set    = 1'b0;
    is_inject = 1'b0;
    unique case (req.req_type)
      btq_pkg::REQ_INJECT_AUTO,
      btq_pkg::REQ_INJECT_AT: begin
        is_push   = 1'b1;
        is_inject = 1'b1;
      end
      btq_pkg::REQ_STUFF: is_push = 1'b1;
      btq_pkg::REQ_YIELD: begin
        is_push  = 1'b1;
        is_drive = 1'b0;
      end
      btq_pkg::REQ_FETCH:    is_fetch = 1'b1;
      btq_pkg::REQ_SET_AUTO: is_set   = 1'b1;
      btq_pkg::REQ_PEEK:     is_peek  = 1'b1;
      default: ;
    endcase
  end

  assign push_addr = (req.req_type == btq_pkg::REQ_INJECT_AUTO) ? auto_addr : req.address;

  always_comb begin
    new_entry.addr  = push_addr[btq_pkg::ADDR_W-1:0];
    new_entry.mask  = is_drive ? btq_pkg::FULL_MASK : req.mask;
    new_entry.value = is_drive ? req.value : 8'd0;
    new_entry.drive = is_drive;
    new_entry.stamp = req.timestamp;
  end

  assign tail_pos  = btq_pkg::idx_add(head_idx, count - btq_pkg::CNT_W'(1));
  assign replace   = (count != '0) && (tail_addr == push_addr[btq_pkg::ADDR_W-1:0]);
  assign full      = (count == btq_pkg::CNT_W'(btq_pkg::DEPTH));
  assign drop      = is_push && !replace && full;

  assign fetch_hit = (count != '0)
                  && (head.addr == (req.address[btq_pkg::ADDR_W-1:0]
                                    & head.mask[btq_pkg::ADDR_W-1:0]))
                  && (head.stamp <= req.timestamp);
  assign pop  = acc && is_fetch && fetch_hit;
  assign show = is_peek ? (count != '0) : (is_fetch && fetch_hit);

  always_comb begin
    wr.en   = acc && is_push && !drop;
    wr.pos  = replace ? tail_pos : btq_pkg::idx_add(head_idx, count);
    wr.data = new_entry;
  end

  always_comb begin
    head_idx_next  = head_idx;
    count_next     = count;
    auto_addr_next = auto_addr;
    tail_addr_next = tail_addr;
    if (acc) begin
      if (wr.en) begin
        tail_addr_next = new_entry.addr;
        if (!replace) begin
          count_next = count + btq_pkg::CNT_W'(1);
        end
        if (is_inject) begin
          auto_addr_next = push_addr + 16'd1;
        end
      end
      if (pop) begin
        head_idx_next = btq_pkg::idx_add(head_idx, btq_pkg::CNT_W'(1));
        count_next    = count - btq_pkg::CNT_W'(1);
      end
      if (is_set) begin
        auto_addr_next = req.address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx  <= '0;
      count     <= '0;
      auto_addr <= '0;
    end else begin
      head_idx  <= head_idx_next;
      count     <= count_next;
      auto_addr <= auto_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    tail_addr <= tail_addr_next;
  end

  btq_store u_store (
    .clk           (clk),
    .wr            (wr),
    .pop           (pop),
    .head_idx      (head_idx),
    .head_idx_next (head_idx_next),
    .head          (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.hit                 <= show;
      rsp.bus_drive           <= show && head.drive;
      rsp.bus_value           <= show ? head.value : 8'd0;
      rsp.head_address        <= show ? head.addr : '0;
      rsp.overflow            <= drop;
      rsp.pending             <= (count_next != '0);
      rsp.entry_count         <= 6'(count_next);
      rsp.next_inject_address <= auto_addr_next;
    end
  end

  `BTQ_ASSERT_NOW(a_count_max, 1'b1, count <= btq_pkg::CNT_W'(btq_pkg::DEPTH), "count above depth")
  `BTQ_ASSERT_NEXT(a_pop_dec, pop, count == $past(count) - btq_pkg::CNT_W'(1), "pop did not decrement")
  `BTQ_ASSERT_NEXT(a_drop_hold, acc && drop, (count == $past(count)) && (auto_addr == $past(auto_addr)), "dropped push changed state")
  `BTQ_ASSERT_NOW(a_pending, rsp.valid, rsp.pending == (rsp.entry_count != 6'd0), "pending disagrees with count")

endmodule
